// ----- hdl/mpso_pkg.sv -----
`timescale 1ns / 1ps

package mpso_pkg;

   // Pattern slot storage and match vector width
   localparam int SLOTS       = 32;
   localparam int CHAR_W      = 8;
   localparam int SLOT_WORDS  = SLOTS / 8;
   localparam int WORD_W      = 64;
   localparam int VEC_W       = 32;
   localparam int SIZE_W      = 6;
   localparam int PROD_W      = 2 * SIZE_W;
   localparam int POS_W       = 32;
   localparam int CSR_IDX_W   = 3;

   // Configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SLOT_A = 3'd0,
      CSR_SLOT_B = 3'd1,
      CSR_SLOT_C = 3'd2,
      CSR_SLOT_D = 3'd3,
      CSR_PCOUNT = 3'd4,
      CSR_PLEN   = 3'd5
   } csr_index_type;

   // Decoded configuration seen by the scan datapath
   typedef struct packed {
      logic [SLOTS-1:0][CHAR_W-1:0] slot_chars;
      logic [SIZE_W-1:0]            pattern_count;
      logic [SIZE_W-1:0]            pattern_len;
      logic                         size_ok;
      logic [VEC_W-1:0]             slot_en;
      logic [VEC_W-1:0]             last_col;
   } cfg_type;

   // One result handed from the scan stage to the output register
   typedef struct packed {
      logic             valid;
      logic [POS_W-1:0] match_start;
   } hit_type;

endpackage

// ----- hdl/mpso_cfg.sv -----
`timescale 1ns / 1ps

module mpso_cfg
   import mpso_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [WORD_W-1:0]    csr_wdata,
   output cfg_type              cfg
);

   logic [SLOT_WORDS-1:0][WORD_W-1:0] slot_words_ff;
   logic [SIZE_W-1:0]                 pcount_ff;
   logic [SIZE_W-1:0]                 plen_ff;
   logic [PROD_W-1:0]                 slot_total;
   logic [PROD_W-1:0]                 col_shift;
   logic [2*VEC_W-1:0]                col_wide;

   // Register writes; indexes past the list are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_words_ff <= '0;
         pcount_ff     <= SIZE_W'(1);
         plen_ff       <= SIZE_W'(1);
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_SLOT_A: slot_words_ff[0] <= csr_wdata;
            CSR_SLOT_B: slot_words_ff[1] <= csr_wdata;
            CSR_SLOT_C: slot_words_ff[2] <= csr_wdata;
            CSR_SLOT_D: slot_words_ff[3] <= csr_wdata;
            CSR_PCOUNT: pcount_ff <= csr_wdata[SIZE_W-1:0];
            CSR_PLEN:   plen_ff   <= csr_wdata[SIZE_W-1:0];
            default: ;
         endcase
      end
   end

   // Derived geometry: active slots and the last column
   assign slot_total = PROD_W'(pcount_ff) * PROD_W'(plen_ff);
   assign col_shift  = PROD_W'(plen_ff - SIZE_W'(1)) * PROD_W'(pcount_ff);
   assign col_wide   = ((2*VEC_W)'(1) << pcount_ff) - (2*VEC_W)'(1);

   always_comb begin
      cfg.slot_chars    = slot_words_ff;
      cfg.pattern_count = pcount_ff;
      cfg.pattern_len   = plen_ff;
      cfg.size_ok       = (pcount_ff != '0) && (plen_ff != '0)
                          && (slot_total <= PROD_W'(SLOTS))
                          && (slot_total <= PROD_W'(VEC_W));
      for (int s = 0; s < VEC_W; s++) begin
         cfg.slot_en[s] = (PROD_W'(s) < slot_total);
      end
      cfg.last_col = VEC_W'(col_wide << col_shift);
   end

endmodule

// ----- hdl/mpso_scan.sv -----
`timescale 1ns / 1ps

module mpso_scan
   import mpso_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [CHAR_W-1:0] text_byte,
   input  logic              text_start,
   input  logic              out_ready,
   output hit_type           hit
);

   logic              s1_valid_ff, s1_valid_in;
   logic [CHAR_W-1:0] s1_byte_ff;
   logic              s1_start_ff;
   logic [VEC_W-1:0]  mv_ff, mv_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic              adv;
   logic [POS_W-1:0]  pos_cur;
   logic [VEC_W-1:0]  mv_base;
   logic [VEC_W-1:0]  char_mask;
   logic [VEC_W-1:0]  mv_next;

   // Input register advances whenever the output side can take a result
   assign adv         = s1_valid_ff && out_ready;
   assign req_tready  = !s1_valid_ff || out_ready;
   assign s1_valid_in = (req_tvalid && req_tready) || (s1_valid_ff && !adv);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_byte_ff  <= text_byte;
         s1_start_ff <= text_start;
      end
   end

   // Mask compare, shift by pattern count and OR
   assign pos_cur = s1_start_ff ? '0 : pos_ff;
   assign mv_base = s1_start_ff ? '1 : mv_ff;

   always_comb begin
      for (int s = 0; s < VEC_W; s++) begin
         char_mask[s] = !(cfg.slot_en[s] && (cfg.slot_chars[s] == s1_byte_ff));
      end
   end

   assign mv_next = (mv_base << cfg.pattern_count) | char_mask;
   assign mv_in   = cfg.size_ok ? mv_next : '1;
   assign pos_in  = pos_cur + POS_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         mv_ff  <= '1;
         pos_ff <= '0;
      end else if (adv) begin
         mv_ff  <= mv_in;
         pos_ff <= pos_in;
      end
   end

   // A zero anywhere in the last column is a match
   always_comb begin
      hit.valid       = adv && cfg.size_ok && ((~mv_next & cfg.last_col) != '0);
      hit.match_start = pos_cur - POS_W'(cfg.pattern_len) + POS_W'(1);
   end

   a_hit_needs_size: assert property (@(posedge clock) disable iff (reset)
      hit.valid |-> cfg.size_ok)
      else $error("match reported with invalid pattern geometry");

   a_bad_size_clears: assert property (@(posedge clock) disable iff (reset)
      (adv && !cfg.size_ok) |=> (mv_ff == '1))
      else $error("match vector not held at all ones for invalid geometry");

   a_pos_advance: assert property (@(posedge clock) disable iff (reset)
      adv |=> (pos_ff == $past(pos_cur) + POS_W'(1)))
      else $error("byte position did not advance by one");

   a_start_pos: assert property (@(posedge clock) disable iff (reset)
      (hit.valid && s1_start_ff) |-> (hit.match_start == POS_W'(1) - POS_W'(cfg.pattern_len)))
      else $error("match start wrong on first byte of a text");

endmodule

// ----- hdl/mpso_out.sv -----
`timescale 1ns / 1ps

module mpso_out
   import mpso_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  hit_type          hit,
   output logic             out_ready,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [POS_W-1:0] rsp_tdata
);

   logic             valid_ff, valid_in;
   logic [POS_W-1:0] data_ff;

   // Result register: refills in the cycle it is drained
   assign out_ready = !valid_ff || rsp_tready;
   assign valid_in  = hit.valid || (valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (hit.valid) begin
         data_ff <= hit.match_start;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;

endmodule

// ----- hdl/multi_pattern_shift_or_matcher_core.sv -----
`timescale 1ns / 1ps
// Channel  | Ports              | Carries
// ---------+--------------------+-------------------------------------------
// input    | req_t*             | tdata: text_byte; tuser: text_start
// result   | rsp_t*             | tdata: match_start (zero or one per byte)
// config   | csr_we/index/wdata | slot chars a..d, pattern count, length
//
// One text byte is accepted per cycle while the result register is not stalled;
// its result passes the input register, then the result register, to rsp_t*.
// The match vector update is a registered loop: compare, shift and OR.
// Reset is synchronous: match vector all ones, position zero, config defaults.
// A stalled result register holds the input register; ready drops only then.

module multi_pattern_shift_or_matcher_core
   import mpso_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [7:0]           req_tdata,   // [7:0] text_byte
   input  logic [0:0]           req_tuser,   // [0] text_start
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [POS_W-1:0]     rsp_tdata,   // [31:0] match_start
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [WORD_W-1:0]    csr_wdata
);

   cfg_type cfg;
   hit_type hit;
   logic    out_ready;

   mpso_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   mpso_scan u_scan (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .text_byte  (req_tdata[CHAR_W-1:0]),
      .text_start (req_tuser[0]),
      .out_ready  (out_ready),
      .hit        (hit)
   );

   mpso_out u_out (
      .clock      (clock),
      .reset      (reset),
      .hit        (hit),
      .out_ready  (out_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ----- verif/match_checker.sv -----
`timescale 1ns / 1ps

// Watches the text and match channels plus the register port, keeps its own
// copy of the shift-or scan and checks every match start the block reports.
module match_checker
   import mpso_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   input  logic                 req_tready,
   input  logic [7:0]           req_tdata,   // [7:0] text_byte
   input  logic [0:0]           req_tuser,   // [0] text_start
   input  logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  logic [POS_W-1:0]     rsp_tdata,   // [31:0] match_start
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [WORD_W-1:0]    csr_wdata,
   output int                   failures,
   output int                   pending,
   output int                   matches_checked
);

   // Shadow copy of the pattern registers
   logic [WORD_W-1:0] slot_words [SLOT_WORDS];
   logic [SIZE_W-1:0] count_cfg;
   logic [SIZE_W-1:0] len_cfg;

   // Shadow scan state
   logic [VEC_W-1:0]  scan_vector;
   logic [POS_W-1:0]  next_pos;

   logic [POS_W-1:0]  expected_starts [$];
   logic [POS_W-1:0]  oldest_start;
   int                fail_tally  = 0;
   int                match_tally = 0;

   task automatic report_mismatch(input string what);
      $display("[%0t] MISMATCH: %s", $time, what);
      fail_tally++;
   endtask

   // One step of the shift-or scan; queues a match start when the last
   // column of the match vector holds a zero.
   function automatic void scan_text_byte(input logic [7:0] text_byte,
                                          input logic text_start);
      logic [POS_W-1:0]   pos;
      logic [PROD_W-1:0]  n;
      logic [VEC_W-1:0]   mask;
      logic [2*VEC_W-1:0] wide;
      logic [2*VEC_W-1:0] col;
      if (text_start) begin
         scan_vector = '1;
         next_pos = '0;
      end
      pos = next_pos;
      next_pos = pos + 1'b1;
      n = count_cfg * len_cfg;
      // invalid size: no result, vector held at all ones
      if (count_cfg == 0 || len_cfg == 0 || n > SLOTS || n > VEC_W) begin
         scan_vector = '1;
         return;
      end
      mask = '1;
      for (int s = 0; s < VEC_W; s++) begin
         if (s < n && slot_words[s / 8][8 * (s % 8) +: 8] == text_byte)
            mask[s] = 1'b0;
      end
      wide = {{VEC_W{1'b0}}, scan_vector} << count_cfg;
      scan_vector = wide[VEC_W-1:0] | mask;
      col = ((64'd1 << count_cfg) - 64'd1)
            << ((int'(len_cfg) - 1) * int'(count_cfg));
      if ((~scan_vector & col[VEC_W-1:0]) != '0)
         expected_starts.push_back(pos - POS_W'(len_cfg) + 1'b1);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         foreach (slot_words[w]) slot_words[w] = '0;
         count_cfg = SIZE_W'(1);
         len_cfg = SIZE_W'(1);
         scan_vector = '1;
         next_pos = '0;
         expected_starts.delete();
      end else begin
         // register writes
         if (csr_we) begin
            case (csr_index)
               CSR_SLOT_A, CSR_SLOT_B, CSR_SLOT_C, CSR_SLOT_D: begin
                  slot_words[csr_index[1:0]] = csr_wdata;
               end
               CSR_PCOUNT: count_cfg = csr_wdata[SIZE_W-1:0];
               CSR_PLEN:   len_cfg = csr_wdata[SIZE_W-1:0];
               default: ;
            endcase
         end
         // accepted text byte
         if (req_tvalid && req_tready)
            scan_text_byte(req_tdata, req_tuser[0]);
         // accepted match transaction
         if (rsp_tvalid && rsp_tready) begin
            if (expected_starts.size() == 0) begin
               report_mismatch($sformatf("match start %h with none expected", rsp_tdata));
            end else begin
               oldest_start = expected_starts.pop_front();
               if (rsp_tdata !== oldest_start)
                  report_mismatch($sformatf("match_start %h, expected %h",
                                            rsp_tdata, oldest_start));
               match_tally++;
            end
         end
      end
      failures        <= fail_tally;
      pending         <= expected_starts.size();
      matches_checked <= match_tally;
   end

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
   import mpso_pkg::*;

   localparam int RANDOM_BYTES = 1400;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int IDLE_PCT     = 24;
   localparam int DRAIN_CYCLES = 6;

   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [7:0]           req_tdata  = '0;   // [7:0] text_byte
   logic [0:0]           req_tuser  = '0;   // [0] text_start
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [POS_W-1:0]     rsp_tdata;         // [31:0] match_start
   logic                 csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index  = CSR_SLOT_A;
   logic [WORD_W-1:0]    csr_wdata  = '0;

   int                   failures;
   int                   pending;
   int                   matches_checked;

   logic                 steady     = 1'b0;
   logic                 fresh_text = 1'b0;
   int                   cycles     = 0;
   int                   bytes_sent = 0;
   int                   settings_used = 0;
   logic [7:0]           slot_bytes [SLOTS];

   multi_pattern_shift_or_matcher_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   match_checker match_check (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .failures        (failures),
      .pending         (pending),
      .matches_checked (matches_checked)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // result side back-pressure
   always @(posedge clock) rsp_tready <= steady || ($urandom_range(99) >= IDLE_PCT);

   // run guard
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // one text transaction, with random gaps before it
   task automatic send_text_byte(input logic [7:0] b, input logic start);
      while (!steady && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tuser  <= start;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      bytes_sent++;
   endtask

   // text byte of a random text: new text on the first byte when fresh_text is set, rarely inside
   task automatic feed_text(input logic [7:0] b);
      send_text_byte(b, fresh_text || ($urandom_range(99) < 2));
      fresh_text = 1'b0;
   endtask

   // stop sending and let every outstanding match drain
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [WORD_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   // load all slot characters and the pattern size; upper bits of the
   // size writes are junk that must be ignored
   task automatic program_setting(input logic [SIZE_W-1:0] p, input logic [SIZE_W-1:0] l);
      logic [WORD_W-1:0] word;
      for (int w = 0; w < SLOT_WORDS; w++) begin
         for (int k = 0; k < 8; k++) word[8 * k +: 8] = slot_bytes[8 * w + k];
         write_csr(csr_index_type'(CSR_SLOT_A + w), word);
      end
      word = {$urandom, $urandom};
      word[SIZE_W-1:0] = p;
      write_csr(CSR_PCOUNT, word);
      word = {$urandom, $urandom};
      word[SIZE_W-1:0] = l;
      write_csr(CSR_PLEN, word);
      csr_we <= 1'b0;
      settings_used++;
   endtask

   // random setting followed by a text built mostly from pattern copies
   task automatic random_phase(input int n_bytes);
      int         p;
      int         l;
      int         pick;
      int         span;
      int         start_count;
      int         idx;
      logic [7:0] base;
      logic [7:0] b;
      pick = $urandom_range(99);
      if (pick < 8) begin
         p = 1;
         l = 1;
      end else if (pick < 14) begin
         p = 32;
         l = 1;
      end else if (pick < 20) begin
         p = 1;
         l = 32;
      end else if (pick < 28) begin
         // sizes that give no result
         case ($urandom_range(3))
            0: begin
               p = 0;
               l = $urandom_range(0, 63);
            end
            1: begin
               p = $urandom_range(1, 63);
               l = 0;
            end
            2: begin
               p = $urandom_range(33, 63);
               l = 1;
            end
            default: begin
               p = $urandom_range(2, 32);
               l = $urandom_range(32 / p + 1, 63);
            end
         endcase
      end else begin
         p = $urandom_range(1, 16);
         l = $urandom_range(1, 32 / p);
      end
      // narrow alphabet so that texts hit the patterns often
      base = 8'($urandom);
      span = $urandom_range(1, 4);
      foreach (slot_bytes[s]) begin
         if ($urandom_range(9) == 0) slot_bytes[s] = 8'($urandom);
         else slot_bytes[s] = base + 8'($urandom_range(span - 1));
      end
      wait_idle();
      program_setting(SIZE_W'(p), SIZE_W'(l));
      steady <= (bytes_sent >= 600 && bytes_sent < 900);
      fresh_text = ($urandom_range(99) < 85);
      start_count = bytes_sent;
      while (bytes_sent - start_count < n_bytes) begin
         if (p >= 1 && l >= 1 && p * l <= 32 && $urandom_range(99) < 55) begin
            idx = $urandom_range(0, p - 1);
            for (int k = 0; k < l; k++) begin
               b = slot_bytes[k * p + idx];
               if ($urandom_range(99) < 5) b = 8'($urandom);
               feed_text(b);
            end
         end else if ($urandom_range(1)) begin
            feed_text(base + 8'($urandom_range(span - 1)));
         end else begin
            feed_text(8'($urandom));
         end
      end
   endtask

   initial begin
      int directed_bytes;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // register defaults: one pattern of one zero byte
      send_text_byte(8'h00, 1'b1);
      send_text_byte(8'hFF, 1'b0);
      send_text_byte(8'h00, 1'b0);

      // two 3-byte patterns "abc" and "xyz", interleaved
      wait_idle();
      foreach (slot_bytes[s]) slot_bytes[s] = '0;
      slot_bytes[0] = "a";
      slot_bytes[1] = "x";
      slot_bytes[2] = "b";
      slot_bytes[3] = "y";
      slot_bytes[4] = "c";
      slot_bytes[5] = "z";
      program_setting(SIZE_W'(2), SIZE_W'(3));
      send_text_byte("q", 1'b1);
      send_text_byte("a", 1'b0);
      send_text_byte("b", 1'b0);
      send_text_byte("c", 1'b0);
      send_text_byte("x", 1'b0);
      send_text_byte("y", 1'b0);
      send_text_byte("z", 1'b0);

      // widest pattern count, byte extremes in the first and last slot
      wait_idle();
      foreach (slot_bytes[s]) slot_bytes[s] = {5'(s), 3'b111};
      slot_bytes[0] = 8'h00;
      program_setting(SIZE_W'(32), SIZE_W'(1));
      send_text_byte(8'hFF, 1'b1);
      send_text_byte(8'h00, 1'b0);
      send_text_byte(8'h80, 1'b0);

      // invalid sizes: too many slots, then a zero count
      wait_idle();
      program_setting(SIZE_W'(8), SIZE_W'(5));
      send_text_byte(8'h00, 1'b1);
      send_text_byte(8'hFF, 1'b0);
      wait_idle();
      program_setting(SIZE_W'(0), SIZE_W'(63));
      send_text_byte(8'h00, 1'b0);

      // size change mid-text: a match one byte into the text reports a
      // start position that wraps below zero
      wait_idle();
      foreach (slot_bytes[s]) slot_bytes[s] = '0;
      slot_bytes[0] = "a";
      slot_bytes[1] = "b";
      slot_bytes[2] = "c";
      slot_bytes[3] = "d";
      program_setting(SIZE_W'(4), SIZE_W'(1));
      send_text_byte("c", 1'b1);
      wait_idle();
      program_setting(SIZE_W'(1), SIZE_W'(4));
      send_text_byte("d", 1'b0);
      directed_bytes = bytes_sent;

      // random texts over random settings
      while (bytes_sent < directed_bytes + RANDOM_BYTES)
         random_phase($urandom_range(40, 120));

      wait_idle();
      $display("Scanned %0d text bytes under %0d pattern settings, %0d match starts compared.",
               bytes_sent, settings_used, matches_checked);
      $display("Settings included invalid sizes, 32x1, 1x32 and mid-text size changes.");
      if (failures == 0 && pending == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
